@@ hdl/srp_pkg.sv @@
// Shared types, constants and helpers for the shelf rectangle packer.
`default_nettype none
package srp_pkg;

    localparam int MaxShelves = 64;
    localparam int ShW = $clog2(MaxShelves);      // shelf index width
    localparam int CntW = $clog2(MaxShelves + 1); // shelf count width
    localparam int FillW = 18;

    localparam logic [1:0] StPlaced   = 2'd0;
    localparam logic [1:0] StTooWide  = 2'd1;
    localparam logic [1:0] StNoShelf  = 2'd2;
    localparam logic [1:0] StFailed   = 2'd3;

    localparam logic CfgWidth = 1'b0;
    localparam logic CfgUnit  = 1'b1;

    typedef struct packed {
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic        first_item;
    } t_in_word;

    typedef struct packed {
        logic [15:0] x_offset;
        logic [15:0] y_offset;
        logic [1:0]  status;
        logic [15:0] atlas_height;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input word, start the unit count
        logic div_step;   // one restoring division step
        logic scan_start; // begin run search at shelf zero
        logic scan_step;  // examine next shelf
        logic place;      // commit the placement or error
        logic wr_step;    // add width to one shelf of the run
        logic clr_step;   // clear one shelf
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic div_done;
        logic skip;       // failed earlier or too wide: no search needed
        logic scan_done;
        logic wr_done;
        logic clr_done;
        logic clr_needed;
    } t_stat;

    function automatic logic [15:0] sat16(input logic [33:0] v);
        return (v > 34'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/srp_datapath.sv @@
// Datapath: shelf fill memory, unit divider, run search and result register.
`default_nettype none
module srp_datapath
    import srp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire t_in_word    i_in,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output t_out_word        o_res
);

    logic [16:0]     r_limit;
    logic [10:0]     r_unit;
    t_in_word        r_in;
    logic [FillW-1:0] r_fill [MaxShelves];
    logic [CntW-1:0] r_used;
    logic            r_failed;
    logic [16:0]     r_units;
    logic [15:0]     r_quot;
    logic [10:0]     r_rem;
    logic [4:0]      r_dcnt;
    logic [CntW-1:0] r_j;       // next shelf to read
    logic [CntW-1:0] r_ri;      // shelf held in the read register
    logic            r_rv;      // read register holds a shelf to examine
    logic [FillW-1:0] r_rd;
    logic [FillW-1:0] r_val;    // fill of the current run of equal shelves
    logic [CntW-1:0] r_len;     // length of that run
    logic [FillW-1:0] r_xval;   // fill of the chosen run
    logic            r_have;
    logic [CntW-1:0] r_found;
    logic [CntW-1:0] r_wcnt;
    t_out_word       r_res;
    logic [17:0]     r_maxw;

    // Atlas width: limit rounded up to a power of two, zero for zero.
    logic [17:0] n_maxw;
    always_comb begin
        logic [16:0] v;
        v = r_limit - 17'd1;
        v = v | (v >> 1);
        v = v | (v >> 2);
        v = v | (v >> 4);
        v = v | (v >> 8);
        v = v | (v >> 16);
        n_maxw = {1'b0, v} + 18'd1;
        if (r_limit == 17'd0) n_maxw = 18'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 17'd1024;
            r_unit  <= 11'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgWidth) r_limit <= i_cfg_data[16:0];
            else                       r_unit  <= i_cfg_data[10:0];
        end
    end

    logic [10:0] div_d;
    assign div_d = (r_unit == 11'd0) ? 11'd1 : r_unit;

    // One restoring division step per cycle.
    logic [11:0] trial;
    assign trial = {r_rem, r_quot[15]} - {1'b0, div_d};

    // The search streams the shelves in order and tracks the run of equal
    // fills that ends at the shelf just read.
    logic             same_run;
    logic [FillW-1:0] n_val;
    logic [CntW-1:0]  n_len;
    logic [FillW:0]   fit_sum;
    logic             hit;
    assign same_run = (r_len != '0) && (r_rd == r_val);
    assign n_val    = same_run ? r_val : r_rd;
    assign n_len    = same_run ? r_len + CntW'(1) : CntW'(1);
    assign fit_sum  = {1'b0, n_val} + (FillW+1)'(r_in.rect_width);
    assign hit      = r_rv && (17'(n_len) >= r_units) && (fit_sum <= {1'b0, r_maxw});

    // Every shelf of the chosen run holds the same fill.
    logic [FillW-1:0] wr_val;
    assign wr_val = r_xval + FillW'(r_in.rect_width);

    logic [CntW-1:0] wr_addr;
    assign wr_addr = r_found + r_wcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= CntW'(1);
            r_failed <= 1'b0;
            r_wcnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_in   <= i_in;
                r_maxw <= n_maxw;
                r_quot <= i_in.rect_height;
                r_rem  <= '0;
                r_dcnt <= '0;
                r_wcnt <= '0;
                if (i_in.first_item) begin
                    r_used   <= CntW'(1);
                    r_failed <= 1'b0;
                end
            end
            if (i_cmd.div_step) begin
                if (!trial[11]) begin
                    r_rem  <= trial[10:0];
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[9:0], r_quot[15]};
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cmd.scan_start) begin
                r_units <= ({1'b0, r_quot} + ((r_rem != 0) ? 17'd1 : 17'd0) == 17'd0)
                           ? 17'd1 : {1'b0, r_quot} + ((r_rem != 0) ? 17'd1 : 17'd0);
                r_j    <= '0;
                r_rv   <= 1'b0;
                r_len  <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (r_j < r_used) begin
                    r_ri <= r_j;
                    r_rv <= 1'b1;
                    r_j  <= r_j + CntW'(1);
                end else begin
                    r_rv <= 1'b0;
                end
                if (r_rv && !r_have) begin
                    r_val <= n_val;
                    r_len <= n_len;
                    if (hit) begin
                        r_have  <= 1'b1;
                        r_found <= r_ri + CntW'(1) - r_units[CntW-1:0];
                        r_xval  <= n_val;
                    end
                end
            end
            if (i_cmd.place) begin
                r_res.x_offset <= '0;
                r_res.y_offset <= '0;
                r_wcnt         <= '0;
                if (r_failed) begin
                    r_res.status <= StFailed;
                    r_res.atlas_height <= sat16(34'(r_used) * 34'(r_unit));
                end else if ({2'b0, r_in.rect_width} > r_maxw) begin
                    r_res.status <= StTooWide;
                    r_failed     <= 1'b1;
                    r_res.atlas_height <= sat16(34'(r_used) * 34'(r_unit));
                end else if (r_have) begin
                    r_res.status   <= StPlaced;
                    r_res.x_offset <= sat16(34'(r_xval));
                    r_res.y_offset <= sat16(34'(r_found) * 34'(r_unit));
                    r_res.atlas_height <= sat16(34'(r_used) * 34'(r_unit));
                end else if (17'(r_used) + r_units > 17'(MaxShelves)) begin
                    r_res.status <= StNoShelf;
                    r_failed     <= 1'b1;
                    r_res.atlas_height <= sat16(34'(r_used) * 34'(r_unit));
                end else begin
                    // Shelves above those in use are still empty.
                    r_res.status   <= StPlaced;
                    r_res.y_offset <= sat16(34'(r_used) * 34'(r_unit));
                    r_res.atlas_height <=
                        sat16(34'(r_used + r_units[CntW-1:0]) * 34'(r_unit));
                    r_xval  <= '0;
                    r_found <= r_used;
                    r_have  <= 1'b1;
                    r_used  <= r_used + r_units[CntW-1:0];
                end
            end
            if (i_cmd.wr_step) r_wcnt <= r_wcnt + CntW'(1);
            if (i_cmd.clr_step) r_wcnt <= r_wcnt + CntW'(1);
        end
    end

    // Fill memory: one write and one registered read per cycle, cleared by a sweep
    // after reset or a first item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            r_fill[r_wcnt[ShW-1:0]] <= '0;
        else if (i_cmd.wr_step && r_have)
            r_fill[wr_addr[ShW-1:0]] <= wr_val;
        if (i_cmd.scan_step)
            r_rd <= r_fill[r_j[ShW-1:0]];
    end

    logic r_clr_need;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_need <= 1'b1;
        else if (i_cmd.load && i_in.first_item) r_clr_need <= 1'b1;
        else if (i_cmd.clr_step && r_wcnt == CntW'(MaxShelves - 1)) r_clr_need <= 1'b0;
    end

    assign o_stat.div_done   = (r_dcnt == 5'd16);
    assign o_stat.skip       = r_failed || ({2'b0, r_in.rect_width} > r_maxw);
    assign o_stat.scan_done  = r_have || (!r_rv && r_j >= r_used);
    assign o_stat.wr_done    = !r_have || (17'(r_wcnt) + 17'd1 >= r_units);
    assign o_stat.clr_done   = (r_wcnt == CntW'(MaxShelves - 1));
    assign o_stat.clr_needed = r_clr_need;
    assign o_res = r_res;

endmodule
`default_nettype wire

@@ hdl/srp_ctrl.sv @@
// Controller state machine sequencing clear, divide, search, place and write.
`default_nettype none
module srp_ctrl
    import srp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SCAN0 = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_PLACE = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_CLR2  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    logic take;
    assign take = (r_state == S_IDLE) && i_in_valid && !r_out_valid;
    assign o_in_stall  = !((r_state == S_IDLE) && !r_out_valid);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CLR2;
                end
            end
            S_CLR2: begin
                if (i_stat.clr_needed) begin
                    o_cmd.clr_step = 1'b1;
                    if (i_stat.clr_done) n_state = S_DIV;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_SCAN0;
                else o_cmd.div_step = 1'b1;
            end
            S_SCAN0: begin
                o_cmd.scan_start = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.skip || i_stat.scan_done) n_state = S_PLACE;
                else o_cmd.scan_step = 1'b1;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_stat.wr_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PLACE) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hdl/shelf_rectangle_packer_top.sv @@
// Top level of the shelf rectangle packer.
//
// Each word passes through these steps from its acceptance to the end of its
// update: the idle state takes the word, a second state checks for a pending
// clear, a 16-step serial divider forms the shelf count, the search reads one
// shelf of the fill memory per cycle among the U shelves in use (up to 64) and
// stops at the first fitting run, the place state places, and the run it is
// placed in is then updated one shelf per cycle (an error updates no shelf).
// After reset, and when a first-item word arrives, a clearing pass sweeps all
// 64 shelves of the fill memory; for a first item it runs in place of the
// single check. The result word appears after the place state and is held
// until taken; the next word is taken once the update is done and the result
// has gone.
`default_nettype none
module shelf_rectangle_packer_top
    import srp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    srp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_out_stall, .o_out_valid,
        .i_stat(stat), .o_cmd(cmd)
    );

    srp_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_in(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index[0]),
        .i_cfg_data, .o_res(o_out_data)
    );

endmodule
`default_nettype wire

@@ hdl/srp_checker.sv @@
// Port-level checker for the shelf rectangle packer, bound to the top level.
`default_nettype none
module srp_checker
    import srp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result waits");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != StPlaced |->
        o_out_data.x_offset == 16'd0 && o_out_data.y_offset == 16'd0)
        else $error("error result with nonzero offset");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind shelf_rectangle_packer_top srp_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
    .o_out_data
);
`default_nettype wire
